FILE: sv/dwp_pkg.sv
package dwp_pkg;

  localparam int unsigned AccW   = 64;
  localparam int unsigned MplW   = 24;
  localparam int unsigned CntW   = 5;
  localparam int unsigned DivW   = 16;
  localparam logic [CntW-1:0] DivSteps = CntW'(DivW);
  localparam logic [CntW-1:0] KpSteps  = CntW'(8);
  localparam logic [CntW-1:0] KiSteps  = CntW'(24);
  localparam logic [CntW-1:0] KdSteps  = CntW'(24);
  localparam logic [CntW-1:0] DtSteps  = CntW'(16);

  typedef enum logic [2:0] {
    REG_TARGET = 3'd0,
    REG_KP     = 3'd1,
    REG_KI     = 3'd2,
    REG_KD     = 3'd3,
    REG_PWM    = 3'd4,
    REG_STOP   = 3'd5
  } dwp_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CALC,
    ST_AREA,
    ST_AREA_W,
    ST_P,
    ST_P_W,
    ST_I,
    ST_I_W,
    ST_D,
    ST_D_W,
    ST_FIN,
    ST_OUT
  } dwp_state_e;

  // Request to the serial multiply-accumulate unit.
  typedef struct packed {
    logic                  start;
    logic [AccW-1:0]       acc_init;
    logic [AccW-1:0]       mcand;
    logic [MplW-1:0]       mplier;
    logic [CntW-1:0]       nbits;
  } dwp_mul_req_t;

endpackage

FILE: sv/dwp_mul.sv
// Shift-and-add multiply-accumulate, one multiplier bit per cycle.
module dwp_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dwp_pkg::dwp_mul_req_t         req_i,
  output logic                          busy_o,
  output logic [dwp_pkg::AccW-1:0]      acc_o
);

  logic [dwp_pkg::AccW-1:0] acc_q, acc_d;
  logic [dwp_pkg::AccW-1:0] mcand_q, mcand_d;
  logic [dwp_pkg::MplW-1:0] mpl_q, mpl_d;
  logic [dwp_pkg::CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    acc_d   = acc_q;
    mcand_d = mcand_q;
    mpl_d   = mpl_q;
    cnt_d   = cnt_q;
    if (req_i.start) begin
      acc_d   = req_i.acc_init;
      mcand_d = req_i.mcand;
      mpl_d   = req_i.mplier;
      cnt_d   = req_i.nbits;
    end else if (cnt_q != '0) begin
      if (mpl_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d = {mcand_q[dwp_pkg::AccW-2:0], 1'b0};
      mpl_d   = {1'b0, mpl_q[dwp_pkg::MplW-1:1]};
      cnt_d   = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    mcand_q <= mcand_d;
    mpl_q   <= mpl_d;
  end

  assign busy_o = (cnt_q != '0);
  assign acc_o  = acc_q;

endmodule

FILE: sv/dwp_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module dwp_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [dwp_pkg::DivW-1:0]      dividend_i,
  input  logic [dwp_pkg::DivW-1:0]      divisor_i,
  output logic                          busy_o,
  output logic [dwp_pkg::DivW-1:0]      quot_o
);

  logic [dwp_pkg::DivW:0]   rem_q, rem_d;
  logic [dwp_pkg::DivW-1:0] dvd_q, dvd_d;
  logic [dwp_pkg::DivW-1:0] dvs_q, dvs_d;
  logic [dwp_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [dwp_pkg::DivW:0]   rem_sh;
  logic [dwp_pkg::DivW+1:0] diff;

  always_comb begin
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    rem_sh = {rem_q[dwp_pkg::DivW-1:0], dvd_q[dwp_pkg::DivW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
    if (start_i) begin
      rem_d = '0;
      dvd_d = dividend_i;
      dvs_d = divisor_i;
      cnt_d = dwp_pkg::DivSteps;
    end else if (cnt_q != '0) begin
      // The quotient bits shift in where the dividend bits leave.
      if (!diff[dwp_pkg::DivW+1]) begin
        rem_d = diff[dwp_pkg::DivW:0];
        dvd_d = {dvd_q[dwp_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        dvd_d = {dvd_q[dwp_pkg::DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = dvd_q;

endmodule

FILE: sv/dual_wheel_position_pid.sv
// A latched wheel skips the area, divide and gain steps; an unlatched wheel runs them on the
// serial multiply unit. A request is taken only when the sequencer is idle, so one request is
// finished before the next is taken, and a result still waiting on the output holds the
// sequencer in its output state until the result register is free.
// Reset (asynchronous, active low) restores the register defaults, clears both wheels'
// areas, previous magnitudes and latches, and sets the direction to forward.
module dual_wheel_position_pid (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // left_count, right_count, elapsed_ms
  input  logic        s_axis_tuser,  // start_move
  // Result channel.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // left_drive, right_drive, forward, done_res
  // Register write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  // Configuration registers.
  logic signed [15:0] target_q;
  logic [7:0]         kp_q;
  logic [23:0]        ki_q;
  logic [23:0]        kd_q;
  logic [14:0]        pwm_q;
  logic [7:0]         stop_q;

  // Per-wheel state; index 0 is the left wheel, index 1 the right one.
  logic [1:0]  latched_q;
  logic [15:0] prev_q [2];
  logic [31:0] area_q [2];
  logic        dir_q;

  // Captured request fields.
  logic [15:0] lc_q, rc_q, dt_q;

  // Sequencer and working registers.
  dwp_pkg::dwp_state_e state_q, state_d;
  logic               wheel_q;
  logic               skip_q;
  logic signed [16:0] err_q;
  logic [15:0]        mag_q;
  logic               chg_neg_q;
  logic signed [16:0] rate_q;
  logic [14:0]        ldrv_q;
  logic [14:0]        rdrv_q;

  // Result register.
  logic        m_valid_q;
  logic [31:0] m_data_q;

  // Serial units.
  dwp_pkg::dwp_mul_req_t   mul_req;
  logic                    mul_busy;
  logic [dwp_pkg::AccW-1:0] mul_acc;
  logic                    div_start;
  logic                    div_busy;
  logic [15:0]             div_quot;

  // Combinational helpers.
  logic [15:0]        cnt_raw;
  logic signed [16:0] cnt_adj;
  logic signed [14:0] pos;
  logic signed [16:0] err;
  logic [15:0]        mag;
  logic [16:0]        chg;
  logic [15:0]        chg_abs;
  logic               sum_pos;
  logic [39:0]        sum_int;
  logic [14:0]        drive;
  logic               out_free;

  dwp_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .busy_o (mul_busy),
    .acc_o  (mul_acc)
  );

  dwp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (chg_abs),
    .divisor_i  (dt_q),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  assign out_free = !m_valid_q || m_axis_tready;

  // The left count runs downwards, so its position reading is the complement.
  // Division by four truncates towards zero, hence the bias of three on negatives.
  always_comb begin
    cnt_raw = wheel_q ? rc_q : ~lc_q;
    cnt_adj = {cnt_raw[15], cnt_raw} + (cnt_raw[15] ? 17'sd3 : 17'sd0);
    pos     = cnt_adj[16:2];
    err     = {target_q[15], target_q} - {{2{pos[14]}}, pos};
    mag     = err[16] ? 16'(-err) : err[15:0];
    chg     = {1'b0, mag_q} - {1'b0, prev_q[wheel_q]};
    chg_abs = chg[16] ? 16'(-chg) : chg[15:0];
  end

  // Drive from the accumulated sum: the sum carries 24 fraction bits.
  always_comb begin
    sum_pos = !mul_acc[63] && (mul_acc != '0);
    sum_int = mul_acc[63:24];
    if (!sum_pos) begin
      drive = '0;
    end else if (sum_int > {25'd0, pwm_q}) begin
      drive = pwm_q;
    end else begin
      drive = sum_int[14:0];
    end
    if (mag_q < {8'd0, stop_q}) begin
      drive = '0;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      dwp_pkg::ST_IDLE:   if (s_axis_tvalid) state_d = dwp_pkg::ST_CALC;
      dwp_pkg::ST_CALC:   state_d = latched_q[wheel_q] ? dwp_pkg::ST_FIN : dwp_pkg::ST_AREA;
      dwp_pkg::ST_AREA:   state_d = dwp_pkg::ST_AREA_W;
      dwp_pkg::ST_AREA_W: if (!mul_busy && !div_busy) state_d = dwp_pkg::ST_P;
      dwp_pkg::ST_P:      state_d = dwp_pkg::ST_P_W;
      dwp_pkg::ST_P_W:    if (!mul_busy) state_d = dwp_pkg::ST_I;
      dwp_pkg::ST_I:      state_d = dwp_pkg::ST_I_W;
      dwp_pkg::ST_I_W:    if (!mul_busy) state_d = dwp_pkg::ST_D;
      dwp_pkg::ST_D:      state_d = dwp_pkg::ST_D_W;
      dwp_pkg::ST_D_W:    if (!mul_busy) state_d = dwp_pkg::ST_FIN;
      dwp_pkg::ST_FIN:    state_d = wheel_q ? dwp_pkg::ST_OUT : dwp_pkg::ST_CALC;
      dwp_pkg::ST_OUT:    if (out_free) state_d = dwp_pkg::ST_IDLE;
      default:            state_d = dwp_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: requests to the serial units.
  always_comb begin
    mul_req   = '0;
    div_start = 1'b0;
    case (state_q)
      dwp_pkg::ST_AREA: begin
        // The area grows by magnitude times elapsed time, wrapping at 32 bits.
        mul_req.start    = 1'b1;
        mul_req.acc_init = {32'd0, area_q[wheel_q]};
        mul_req.mcand    = {48'd0, mag_q};
        mul_req.mplier   = {8'd0, dt_q};
        mul_req.nbits    = dwp_pkg::DtSteps;
        div_start        = 1'b1;
      end
      dwp_pkg::ST_P: begin
        mul_req.start    = 1'b1;
        mul_req.acc_init = '0;
        mul_req.mcand    = {24'd0, mag_q, 24'd0};
        mul_req.mplier   = {16'd0, kp_q};
        mul_req.nbits    = dwp_pkg::KpSteps;
      end
      dwp_pkg::ST_I: begin
        mul_req.start    = 1'b1;
        mul_req.acc_init = mul_acc;
        mul_req.mcand    = {{32{area_q[wheel_q][31]}}, area_q[wheel_q]};
        mul_req.mplier   = ki_q;
        mul_req.nbits    = dwp_pkg::KiSteps;
      end
      dwp_pkg::ST_D: begin
        // The derivative gain has 8 fraction bits, so the rate is lifted by 16.
        mul_req.start    = 1'b1;
        mul_req.acc_init = mul_acc;
        mul_req.mcand    = {{31{rate_q[16]}}, rate_q, 16'd0};
        mul_req.mplier   = kd_q;
        mul_req.nbits    = dwp_pkg::KdSteps;
      end
      default: begin
        mul_req   = '0;
        div_start = 1'b0;
      end
    endcase
  end

  assign s_axis_tready = (state_q == dwp_pkg::ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dwp_pkg::ST_IDLE;
      target_q  <= '0;
      kp_q      <= 8'd4;
      ki_q      <= 24'd3355;
      kd_q      <= 24'd281600;
      pwm_q     <= 15'd4000;
      stop_q    <= 8'd5;
      latched_q <= '0;
      prev_q[0] <= '0;
      prev_q[1] <= '0;
      area_q[0] <= '0;
      area_q[1] <= '0;
      dir_q     <= 1'b1;
      wheel_q   <= 1'b0;
      skip_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i) begin
        case (cfg_index_i)
          dwp_pkg::REG_TARGET: target_q <= cfg_data_i[15:0];
          dwp_pkg::REG_KP:     kp_q     <= cfg_data_i[7:0];
          dwp_pkg::REG_KI:     ki_q     <= cfg_data_i;
          dwp_pkg::REG_KD:     kd_q     <= cfg_data_i;
          dwp_pkg::REG_PWM:    pwm_q    <= cfg_data_i[14:0];
          dwp_pkg::REG_STOP:   stop_q   <= cfg_data_i[7:0];
          default: ;
        endcase
      end

      // A new result replaces the one leaving in the same cycle.
      if (state_q == dwp_pkg::ST_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        dwp_pkg::ST_IDLE: begin
          wheel_q <= 1'b0;
          // A start request clears both wheels before the step is computed.
          if (s_axis_tvalid && s_axis_tuser) begin
            latched_q <= '0;
            prev_q[0] <= '0;
            prev_q[1] <= '0;
            area_q[0] <= '0;
            area_q[1] <= '0;
          end
        end
        dwp_pkg::ST_CALC: begin
          skip_q <= latched_q[wheel_q];
        end
        dwp_pkg::ST_AREA_W: begin
          if (!mul_busy && !div_busy) begin
            area_q[wheel_q] <= mul_acc[31:0];
            prev_q[wheel_q] <= mag_q;
          end
        end
        dwp_pkg::ST_FIN: begin
          if (!skip_q) begin
            dir_q <= !err_q[16] && (err_q != '0);
            if (mag_q <= 16'd2) begin
              latched_q[wheel_q] <= 1'b1;
            end
          end
          wheel_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == dwp_pkg::ST_IDLE && s_axis_tvalid) begin
      lc_q <= s_axis_tdata[15:0];
      rc_q <= s_axis_tdata[31:16];
      dt_q <= s_axis_tdata[47:32];
    end
    if (state_q == dwp_pkg::ST_CALC) begin
      err_q <= err;
      mag_q <= mag;
    end
    if (state_q == dwp_pkg::ST_AREA) begin
      chg_neg_q <= chg[16];
    end
    if (state_q == dwp_pkg::ST_AREA_W) begin
      // The rate truncates towards zero and is nought when no time has passed.
      if (dt_q == '0) begin
        rate_q <= '0;
      end else if (chg_neg_q) begin
        rate_q <= -$signed({1'b0, div_quot});
      end else begin
        rate_q <= $signed({1'b0, div_quot});
      end
    end
    if (state_q == dwp_pkg::ST_FIN && !wheel_q) begin
      ldrv_q <= skip_q ? 15'd0 : drive;
    end
    if (state_q == dwp_pkg::ST_OUT && out_free) begin
      m_data_q[14:0]  <= ldrv_q;
      m_data_q[29:15] <= rdrv_q;
      m_data_q[30]    <= dir_q;
      m_data_q[31]    <= (ldrv_q == '0) && (rdrv_q == '0);
    end
  end

  // The right drive is held from its final step until the result is written.
  always_ff @(posedge clk_i) begin
    if (state_q == dwp_pkg::ST_FIN && wheel_q) begin
      rdrv_q <= skip_q ? 15'd0 : drive;
    end
  end

endmodule

FILE: tb/sv/tb_dual_wheel_position_pid.sv
module tb_dual_wheel_position_pid;

  // Pause before a register write and after the last result, long enough for the
  // block to finish any request, with room to spare.
  localparam int unsigned SettleCycles = 400;
  // The watchdog limit covers one slow request behind a long result stall
  // and a long source gap, taken several times over.
  localparam int unsigned StallLimit   = 4000;

  typedef struct packed {
    logic        done_res;
    logic        forward;
    logic [14:0] right_drive;
    logic [14:0] left_drive;
  } pid_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;

  always #4 clk_i = ~clk_i;

  dual_wheel_position_pid i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Shadow copy of the registers and the per-wheel controller state.
  logic signed [15:0] target_q;
  logic [7:0]         kp_q;
  logic [23:0]        ki_q;
  logic [23:0]        kd_q;
  logic [14:0]        pwm_max_q;
  logic [7:0]         stop_band_q;
  logic               latched_q[2];
  logic [15:0]        prev_mag_q[2];
  logic [31:0]        area_q[2];
  logic               direction_q;

  pid_result_t drive_queue[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit          gaps_enabled = 1'b1;
  int unsigned stall_left = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  function automatic void reset_shadow();
    target_q    = 16'sd0;
    kp_q        = 8'd4;
    ki_q        = 24'd3355;
    kd_q        = 24'd281600;
    pwm_max_q   = 15'd4000;
    stop_band_q = 8'd5;
    for (int w = 0; w < 2; w++) begin
      latched_q[w]  = 1'b0;
      prev_mag_q[w] = '0;
      area_q[w]     = '0;
    end
    direction_q = 1'b1;
  endfunction

  // One wheel's control update; the area wraps at 32 bits and the gain products are formed exactly in 64 bits.
  function automatic logic [14:0] wheel_drive(input int w, input logic [15:0] cnt,
                                              input logic [15:0] dt);
    logic signed [31:0] pos;
    logic signed [31:0] err;
    longint             mag;
    longint             rate;
    longint             sum;
    logic [14:0]        drive;
    if (latched_q[w]) begin
      return '0;
    end
    pos = $signed(cnt) / 4;
    err = 32'(target_q) - pos;
    mag = longint'((err < 0) ? -err : err);
    area_q[w] = area_q[w] + 32'(mag) * 32'(dt);
    rate = (dt == 0) ? 64'sd0 : (mag - longint'(prev_mag_q[w])) / longint'(dt);
    prev_mag_q[w] = mag[15:0];
    sum = mag * longint'(kp_q) * 64'sd16777216
        + longint'($signed(area_q[w])) * longint'(ki_q)
        + rate * longint'(kd_q) * 64'sd65536;
    if (sum <= 0) begin
      drive = '0;
    end else begin
      sum = sum / 64'sd16777216;
      drive = (sum > longint'(pwm_max_q)) ? pwm_max_q : sum[14:0];
    end
    if (mag < longint'(stop_band_q)) begin
      drive = '0;
    end
    direction_q = (err > 0);
    if (mag <= 2) begin
      latched_q[w] = 1'b1;
    end
    return drive;
  endfunction

  function automatic pid_result_t predict_step(input logic start, input logic [15:0] lc,
                                               input logic [15:0] rc, input logic [15:0] dt);
    pid_result_t r;
    if (start) begin
      for (int w = 0; w < 2; w++) begin
        latched_q[w] = 1'b0;
        prev_mag_q[w] = '0;
        area_q[w] = '0;
      end
    end
    r.left_drive  = wheel_drive(0, 16'hFFFF - lc, dt);
    r.right_drive = wheel_drive(1, rc, dt);
    r.forward     = direction_q;
    r.done_res    = (r.left_drive == 0) && (r.right_drive == 0);
    return r;
  endfunction

  // Random source gap, now and then.
  task automatic source_gap();
    if (gaps_enabled && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  // Sends one request and records its expected result once accepted. The valid
  // stays high so that the next request can follow straight on.
  task automatic send_request(input logic start, input logic [15:0] lc,
                              input logic [15:0] rc, input logic [15:0] dt);
    source_gap();
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= start;
    s_axis_tdata  <= {dt, rc, lc};
    do @(posedge clk_i); while (!s_axis_tready);
    drive_queue.push_back(predict_step(start, lc, rc, dt));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (drive_queue.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input dwp_pkg::dwp_reg_e idx, input logic [23:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      dwp_pkg::REG_TARGET: target_q    = value[15:0];
      dwp_pkg::REG_KP:     kp_q        = value[7:0];
      dwp_pkg::REG_KI:     ki_q        = value;
      dwp_pkg::REG_KD:     kd_q        = value;
      dwp_pkg::REG_PWM:    pwm_max_q   = value[14:0];
      dwp_pkg::REG_STOP:   stop_band_q = value[7:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Counts in quarter units near the target so that errors stay small.
  function automatic logic [15:0] near_count(input int offset);
    return 16'(int'(target_q) * 4 + offset);
  endfunction

  // Result side: stalls in random bursts, and a check of each result.
  always @(posedge clk_i) begin
    pid_result_t got;
    pid_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (drive_queue.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, 32'd0);
      end else begin
        want = drive_queue.pop_front();
        if (got.left_drive != want.left_drive)
          report_mismatch("left_drive", 32'(got.left_drive), 32'(want.left_drive));
        if (got.right_drive != want.right_drive)
          report_mismatch("right_drive", 32'(got.right_drive), 32'(want.right_drive));
        if (got.forward != want.forward)
          report_mismatch("forward", 32'(got.forward), 32'(want.forward));
        if (got.done_res != want.done_res)
          report_mismatch("done_res", 32'(got.done_res), 32'(want.done_res));
      end
    end
    if (!gaps_enabled) begin
      stall_left    <= 0;
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left    <= $urandom_range(1, 18);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog on cycles in which no request, result or register write passes.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Field extremes, zero time, zero error and latching at reset settings.
  task automatic test_directed_steps();
    send_request(1'b1, 16'hFFFF, 16'h0000, 16'd0);
    send_request(1'b0, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_request(1'b1, 16'h7FFF, 16'h8000, 16'd1);
    send_request(1'b0, 16'h8000, 16'h7FFF, 16'd10);
    send_request(1'b1, 16'hFFFF - 16'd400, 16'd400, 16'd5);
    send_request(1'b0, 16'hFFFF - 16'd300, 16'd300, 16'd0);
    // Errors of 2 or less latch both wheels; the next steps drive zero.
    send_request(1'b0, 16'hFFFF - 16'd8, 16'd8, 16'd3);
    send_request(1'b0, 16'hFFFF - 16'd800, 16'd800, 16'd3);
    // A start with latched wheels computes them afresh in the same step.
    send_request(1'b1, 16'hFFFF - 16'd800, 16'd800, 16'd3);
    send_request(1'b0, 16'hFFFF, 16'hFFFC, 16'd2);
    send_request(1'b0, 16'hFFFF - 16'd40, 16'd24, 16'd7);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    write_register(dwp_pkg::REG_TARGET, 24'h007FFF);
    write_register(dwp_pkg::REG_KP, 24'd255);
    write_register(dwp_pkg::REG_KI, 24'hFFFFFF);
    write_register(dwp_pkg::REG_KD, 24'hFFFFFF);
    write_register(dwp_pkg::REG_PWM, 24'h007FFF);
    write_register(dwp_pkg::REG_STOP, 24'd255);
    send_request(1'b1, 16'hFFFF, 16'h0000, 16'd1);
    send_request(1'b0, 16'h0000, 16'h7FFF, 16'hFFFF);
    send_request(1'b0, 16'h8000, 16'h8000, 16'd0);
    wait_idle();
    write_register(dwp_pkg::REG_TARGET, 24'h008000);
    write_register(dwp_pkg::REG_KP, 24'd0);
    write_register(dwp_pkg::REG_KI, 24'd0);
    write_register(dwp_pkg::REG_KD, 24'd0);
    write_register(dwp_pkg::REG_PWM, 24'd0);
    write_register(dwp_pkg::REG_STOP, 24'd0);
    send_request(1'b1, 16'h0000, 16'hFFFF, 16'd9);
    send_request(1'b0, 16'h7FFF, 16'h8000, 16'd4);
  endtask

  // Moves: a start, then counts closing in on the target, with noise steps.
  task automatic test_random_moves(input int unsigned n_items);
    int unsigned sent;
    int          span;
    int          lofs;
    int          rofs;
    logic [15:0] dt;
    sent = 0;
    while (sent < n_items) begin
      wait_idle();
      write_register(dwp_pkg::REG_TARGET,
                     24'($signed(16'($urandom_range(0, 65535))) >>> $urandom_range(0, 15)));
      write_register(dwp_pkg::REG_KP, 24'($urandom_range(0, 255)));
      write_register(dwp_pkg::REG_KI,
                     24'($urandom_range(0, 16777215)) >> $urandom_range(0, 20));
      write_register(dwp_pkg::REG_KD,
                     24'($urandom_range(0, 16777215)) >> $urandom_range(0, 20));
      write_register(dwp_pkg::REG_PWM, 24'($urandom_range(0, 32767)) >> $urandom_range(0, 8));
      write_register(dwp_pkg::REG_STOP, 24'($urandom_range(0, 255)) >> $urandom_range(0, 6));
      span = $urandom_range(40, 4000);
      send_request(1'b1, near_count(span), near_count(span), 16'($urandom_range(0, 20)));
      sent++;
      for (int k = 0; k < 30 && sent < n_items; k++) begin
        span = span * $urandom_range(1, 9) / 10;
        lofs = span + $urandom_range(0, 12) - 6;
        rofs = span + $urandom_range(0, 12) - 6;
        dt = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                         : 16'($urandom_range(0, 30));
        if ($urandom_range(0, 9) == 0) begin
          send_request(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)), dt);
        end else begin
          send_request(1'b0, 16'hFFFF - near_count(lofs), near_count(rofs), dt);
        end
        sent++;
      end
    end
  endtask

  initial begin
    reset_shadow();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_steps();
    test_register_extremes();
    test_random_moves(620);
    gaps_enabled = 1'b0;
    test_random_moves(180);
    wait_idle();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
